### rtl/core/vlos_pkg.sv
// ============================================================================
// vlos_pkg: shared types and constants for the voxel line-of-sight block
// Holds the command codes and the controller/datapath command and status types.
// ============================================================================
package vlos_pkg;

    // input item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture a query and set up the three axes
        logic step;   // advance the walk by one crossing
        logic check;  // marks the check of the map bit read for the entered cell
        logic write;  // write one map cell
        logic clear;  // clear one map cell during the sweep after reset
    } vlos_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic near;      // source and target share an xz column or are xz-adjacent
        logic done;      // no crossing left before the target
        logic own_col;   // entered cell lies in the source or target column
        logic hit;       // entered cell is opaque
        logic sweep_end; // last cell of the clearing sweep
    } vlos_stat_t;

endpackage

### rtl/core/voxel_line_of_sight.sv
// ============================================================================
// voxel_line_of_sight: voxel grid line-of-sight engine
// Opaque cell map with writes, and 3d dda line-of-sight queries.
// ============================================================================
// After reset the block clears its map one cell a cycle, all GRID_SIZE^3 cells
// (4096 at the default size), before taking the first item. Writes are done in
// idle, as are queries whose target is in or xz-next to the source column.
// Other queries load the axes, then each cell the ray enters takes a crossing
// pick, a map read and a check; a last pick finds the walk finished when
// nothing blocks. A walk enters about 3*GRID_SIZE cells at most, read through
// the single registered map read port. One item is worked on at a time.
module voxel_line_of_sight #(
    parameter int GRID_SIZE        = 16,
    parameter int HEIGHT_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, from_height, to_height, opaque
    input  logic [47:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // visible, hit_x, hit_y, hit_z
    output logic [15:0] m_tdata
);
    import vlos_pkg::*;

    vlos_cmd_t  cmd;
    vlos_stat_t stat, stat_dp;
    logic [3:0] fx, fy, fz, tx, ty, tz, hx, hy, hz;
    logic [8:0] fh, th;
    logic [3:0] adx, adz;
    logic       near, in_range;
    logic [12:0] od;

    assign fx = s_tdata[3:0];
    assign fy = s_tdata[7:4];
    assign fz = s_tdata[11:8];
    assign tx = s_tdata[15:12];
    assign ty = s_tdata[19:16];
    assign tz = s_tdata[23:20];
    assign fh = s_tdata[32:24];
    assign th = s_tdata[41:33];

    // near test and write range check
    assign adx  = (fx > tx) ? fx - tx : tx - fx;
    assign adz  = (fz > tz) ? fz - tz : tz - fz;
    assign near = (5'(adx) + 5'(adz)) <= 5'd1;
    assign in_range = (7'(fx) < 7'(GRID_SIZE)) && (7'(fy) < 7'(GRID_SIZE)) &&
                      (7'(fz) < 7'(GRID_SIZE));

    always_comb begin
        stat      = stat_dp;
        stat.near = near;
    end

    vlos_datapath #(.GRID_SIZE(GRID_SIZE), .HEIGHT_FRAC_BITS(HEIGHT_FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .stat(stat_dp),
        .in_fx(fx), .in_fy(fy), .in_fz(fz), .in_tx(tx), .in_ty(ty), .in_tz(tz),
        .in_fh(fh), .in_th(th), .in_opaque(s_tdata[42]),
        .hit_x(hx), .hit_y(hy), .hit_z(hz)
    );

    vlos_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_query(s_tuser),
        .in_near(stat.near), .in_range(in_range),
        .cmd, .stat, .hit_x(hx), .hit_y(hy), .hit_z(hz),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
    );

    assign m_tdata = {3'd0, od};

endmodule

### rtl/core/vlos_datapath.sv
// ============================================================================
// vlos_datapath: opaque map memory and 3d dda stepping datapath
// Holds the axis registers, the crossing-time compares and the map memory.
// ============================================================================
module vlos_datapath #(
    parameter int GRID_SIZE        = 16,
    parameter int HEIGHT_FRAC_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  vlos_pkg::vlos_cmd_t cmd,
    output vlos_pkg::vlos_stat_t stat,
    input  logic [3:0]          in_fx,
    input  logic [3:0]          in_fy,
    input  logic [3:0]          in_fz,
    input  logic [3:0]          in_tx,
    input  logic [3:0]          in_ty,
    input  logic [3:0]          in_tz,
    input  logic [8:0]          in_fh,
    input  logic [8:0]          in_th,
    input  logic                in_opaque,
    output logic [3:0]          hit_x,
    output logic [3:0]          hit_y,
    output logic [3:0]          hit_z
);
    import vlos_pkg::*;

    localparam int CB    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AB    = 3 * CB;
    localparam int IW    = 4;                               // input coordinate width
    // position width: input cell index, fraction, and room for large heights
    localparam int PW    = IW + HEIGHT_FRAC_BITS + 2;
    localparam int SB    = PW - HEIGHT_FRAC_BITS + 2;       // signed cell width
    localparam int DW    = PW + 1;                          // dist/span width
    localparam int MW    = 2 * DW;
    localparam logic [PW-1:0] HALF = PW'(1) << (HEIGHT_FRAC_BITS - 1);
    localparam logic [DW-1:0] UNIT = DW'(1) << HEIGHT_FRAC_BITS;

    // map memory, one bit a cell
    logic map_mem [CELLS];
    logic rd_reg;
    logic [AB-1:0] sweep_reg, sweep_next;

    // axis state
    logic signed [SB-1:0] cell_reg [3], cell_next [3];
    logic [1:0]           dir_reg  [3], dir_next  [3];  // {neg, moving}
    logic [DW-1:0]        dist_reg [3], dist_next [3];
    logic [DW-1:0]        span_reg [3], span_next [3];
    logic [3:0] fx_reg, fz_reg, tx_reg, tz_reg;
    logic [3:0] fx_next, fz_next, tx_next, tz_next;

    // ray endpoints for the load
    logic [PW-1:0] st [3], en [3];
    always_comb begin
        st[0] = (PW'(in_fx) << HEIGHT_FRAC_BITS) + HALF;
        en[0] = (PW'(in_tx) << HEIGHT_FRAC_BITS) + HALF;
        st[1] = (PW'(in_fy) << HEIGHT_FRAC_BITS) + PW'(in_fh) + HALF;
        en[1] = (PW'(in_ty) << HEIGHT_FRAC_BITS) + PW'(in_th) + HALF;
        st[2] = (PW'(in_fz) << HEIGHT_FRAC_BITS) + HALF;
        en[2] = (PW'(in_tz) << HEIGHT_FRAC_BITS) + HALF;
    end

    // cross products: one multiplier pair per axis against each other axis
    logic [MW-1:0] prod [3][3];   // prod[i][j] = dist_i * span_j
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod[i][j] = MW'(dist_reg[i]) * MW'(span_reg[j]);
    end

    // pick the earliest crossing: axis i wins if no other moving axis is earlier
    logic [2:0] tie;
    logic       any_move;
    logic       m_late;
    always_comb begin
        logic [2:0] best;
        best = '0;
        for (int i = 0; i < 3; i++) begin
            best[i] = dir_reg[i][0];
            for (int j = 0; j < 3; j++)
                if (j != i && dir_reg[j][0] && prod[j][i] < prod[i][j])
                    best[i] = 1'b0;
        end
        tie      = best;
        any_move = dir_reg[0][0] | dir_reg[1][0] | dir_reg[2][0];
        m_late   = 1'b0;
        for (int i = 0; i < 3; i++)
            if (best[i] && dist_reg[i] > span_reg[i])
                m_late = 1'b1;
    end

    // entered cell column / grid checks
    logic signed [SB-1:0] cy;
    logic in_grid;
    assign cy  = cell_reg[1];
    assign in_grid = (cy >= 0) && (cy < SB'(GRID_SIZE)) &&
                     (cell_reg[0] < SB'(GRID_SIZE)) && (cell_reg[2] < SB'(GRID_SIZE));

    assign stat.near      = 1'b0;
    assign stat.done      = !any_move || m_late;
    assign stat.own_col   = (cell_reg[0] == SB'(fx_reg) && cell_reg[2] == SB'(fz_reg)) ||
                            (cell_reg[0] == SB'(tx_reg) && cell_reg[2] == SB'(tz_reg));
    assign stat.hit       = rd_reg && in_grid;
    assign stat.sweep_end = (sweep_reg == AB'(CELLS - 1));

    assign hit_x = 4'(cell_reg[0]);
    assign hit_y = 4'(cell_reg[1]);
    assign hit_z = 4'(cell_reg[2]);

    // axis update logic
    always_comb begin
        fx_next = fx_reg; fz_next = fz_reg; tx_next = tx_reg; tz_next = tz_reg;
        sweep_next = sweep_reg;
        for (int i = 0; i < 3; i++) begin
            cell_next[i] = cell_reg[i];
            dir_next[i]  = dir_reg[i];
            dist_next[i] = dist_reg[i];
            span_next[i] = span_reg[i];
        end
        if (cmd.clear)
            sweep_next = sweep_reg + AB'(1);
        if (cmd.load) begin
            fx_next = in_fx; fz_next = in_fz; tx_next = in_tx; tz_next = in_tz;
            for (int i = 0; i < 3; i++) begin
                cell_next[i] = SB'(st[i] >> HEIGHT_FRAC_BITS);
                dir_next[i]  = {en[i] < st[i], en[i] != st[i]};
                span_next[i] = (en[i] < st[i]) ? DW'(st[i] - en[i]) : DW'(en[i] - st[i]);
                if (en[i] > st[i])
                    dist_next[i] = UNIT - DW'(st[i][HEIGHT_FRAC_BITS-1:0]);
                else
                    dist_next[i] = DW'(st[i][HEIGHT_FRAC_BITS-1:0]);
            end
        end else if (cmd.step) begin
            for (int i = 0; i < 3; i++)
                if (tie[i]) begin
                    cell_next[i] = dir_reg[i][1] ? cell_reg[i] - SB'(1) : cell_reg[i] + SB'(1);
                    dist_next[i] = dist_reg[i] + UNIT;
                end
        end
    end

    // axis registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
        fx_reg <= fx_next; fz_reg <= fz_next; tx_reg <= tx_next; tz_reg <= tz_next;
        for (int i = 0; i < 3; i++) begin
            cell_reg[i] <= cell_next[i];
            dir_reg[i]  <= dir_next[i];
            dist_reg[i] <= dist_next[i];
            span_reg[i] <= span_next[i];
        end
    end

    // map memory port: one write, one registered read of the next cell
    logic [AB-1:0] rd_addr;
    assign rd_addr = {cell_next[2][CB-1:0], cell_next[1][CB-1:0], cell_next[0][CB-1:0]};
    always_ff @(posedge aclk) begin
        if (cmd.clear)
            map_mem[sweep_reg] <= 1'b0;
        else if (cmd.write)
            map_mem[{CB'(in_fz), CB'(in_fy), CB'(in_fx)}] <= in_opaque;
        rd_reg <= map_mem[rd_addr];
    end

endmodule

### rtl/core/vlos_ctrl.sv
// ============================================================================
// vlos_ctrl: controller for the voxel line-of-sight block
// Runs the clearing sweep, takes items, sequences the dda walk, holds results.
// ============================================================================
module vlos_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_query,
    input  logic                 in_near,
    input  logic                 in_range,
    output vlos_pkg::vlos_cmd_t  cmd,
    input  vlos_pkg::vlos_stat_t stat,
    input  logic [3:0]           hit_x,
    input  logic [3:0]           hit_y,
    input  logic [3:0]           hit_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [12:0]          out_data
);
    import vlos_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        ov_reg, ov_next;
    logic [12:0] od_reg, od_next;
    logic        acc;

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // state sequencing
    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.sweep_end) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    if (in_query == CMD_WRITE) begin
                        cmd.write = in_range;
                    end else if (in_near) begin
                        ov_next = 1'b1;
                        od_next = {12'd0, 1'b1};
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (stat.done) begin
                    ov_next    = 1'b1;
                    od_next    = {12'd0, 1'b1};
                    state_next = ST_IDLE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_CHECK;
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (!stat.own_col && stat.hit) begin
                    ov_next    = 1'b1;
                    od_next    = {hit_z, hit_y, hit_x, 1'b0};
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_STEP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        od_reg <= od_next;
    end

    // no item is taken while busy, a result holds under a stall, a blocked result follows a check
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("item taken while walking");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(od_reg)))
        else $error("result lost under stall");
    a_blocked_has_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(ov_reg) && !od_reg[0]) |-> ($past(state_reg) == ST_CHECK))
        else $error("blocked result without a check");

endmodule
